// File: rtl/i2cee_pkg.sv
package i2cee_pkg;

  localparam int unsigned PHASE_W = 4;

  localparam logic [PHASE_W-1:0] LEN_WRITE = PHASE_W'(8);
  localparam logic [PHASE_W-1:0] LEN_READ  = PHASE_W'(11);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_SPARE = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    SEG_START = 4'd0,
    SEG_DEVW  = 4'd1,
    SEG_ADDR  = 4'd2,
    SEG_DATA  = 4'd3,
    SEG_DEVR  = 4'd4,
    SEG_ACK   = 4'd5,
    SEG_READ  = 4'd6,
    SEG_NACK  = 4'd7,
    SEG_STOP  = 4'd8
  } seg_t;

  // Bus lines and status for one word
  typedef struct packed {
    logic [7:0] rx_data;
    logic       ack_error;
    logic       done_res;
    logic       busy_res;
    logic       sda_pull_low;
    logic       scl;
  } res_t;

  // Segment sequence of each transaction
  function automatic seg_t seg_kind(input logic rd, input logic [PHASE_W-1:0] idx);
    seg_t k;
    k = SEG_STOP;
    if (!rd) begin
      case (idx)
        4'd0:    k = SEG_START;
        4'd1:    k = SEG_DEVW;
        4'd2:    k = SEG_ACK;
        4'd3:    k = SEG_ADDR;
        4'd4:    k = SEG_ACK;
        4'd5:    k = SEG_DATA;
        4'd6:    k = SEG_ACK;
        default: k = SEG_STOP;
      endcase
    end else begin
      case (idx)
        4'd0:    k = SEG_START;
        4'd1:    k = SEG_DEVW;
        4'd2:    k = SEG_ACK;
        4'd3:    k = SEG_ADDR;
        4'd4:    k = SEG_ACK;
        4'd5:    k = SEG_START;
        4'd6:    k = SEG_DEVR;
        4'd7:    k = SEG_ACK;
        4'd8:    k = SEG_READ;
        4'd9:    k = SEG_NACK;
        default: k = SEG_STOP;
      endcase
    end
    return k;
  endfunction

endpackage

// File: rtl/i2cee_seq.sv
module i2cee_seq
  import i2cee_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [1:0] opcode,
  input  logic [7:0] word_address,
  input  logic [7:0] write_data,
  input  logic       sda_in,
  input  logic [6:0] slave_addr,
  output res_t       res
);

  logic [PHASE_W-1:0] phase, phase_next;
  logic [2:0]         bit_count, bit_count_next;
  logic [1:0]         half_step, half_step_next;
  logic [7:0]         shift_byte, shift_byte_next;
  logic               is_read, is_read_next;
  logic [7:0]         latched_address, latched_address_next;
  logic [7:0]         latched_data, latched_data_next;
  logic [7:0]         received_byte, received_byte_next;
  logic               ack_fail, ack_fail_next;

  seg_t               kind;
  logic [PHASE_W-1:0] len;
  logic [7:0]         src_byte;
  logic [7:0]         sb_cur;
  logic [2:0]         bc_inc;
  logic               scl, pull, done;

  always_comb begin
    kind     = seg_kind(is_read, phase - PHASE_W'(1));
    len      = is_read ? LEN_READ : LEN_WRITE;
    bc_inc   = bit_count + 3'd1;
    src_byte = latched_data;
    unique case (kind)
      SEG_DEVW: src_byte = {slave_addr, 1'b0};
      SEG_DEVR: src_byte = {slave_addr, 1'b1};
      SEG_ADDR: src_byte = latched_address;
      default:  src_byte = latched_data;
    endcase
    sb_cur = (half_step == 2'd0 && bit_count == 3'd0) ? src_byte : shift_byte;

    phase_next           = phase;
    bit_count_next       = bit_count;
    half_step_next       = half_step;
    shift_byte_next      = shift_byte;
    is_read_next         = is_read;
    latched_address_next = latched_address;
    latched_data_next    = latched_data;
    received_byte_next   = received_byte;
    ack_fail_next        = ack_fail;
    scl  = 1'b1;
    pull = 1'b0;
    done = 1'b0;

    if (phase == '0) begin
      if (opcode == OP_WRITE || opcode == OP_READ) begin
        is_read_next         = (opcode == OP_READ);
        latched_address_next = word_address;
        latched_data_next    = write_data;
        ack_fail_next        = 1'b0;
        if (opcode == OP_READ) received_byte_next = '0;
        phase_next     = PHASE_W'(1);
        half_step_next = '0;
        bit_count_next = '0;
      end
    end else if (phase > len) begin
      phase_next = '0;
    end else begin
      unique case (kind)
        SEG_START: begin
          scl  = (half_step == 2'd1 || half_step == 2'd2);
          pull = half_step[1];
          if (half_step == 2'd3) begin
            phase_next     = phase + PHASE_W'(1);
            half_step_next = '0;
            bit_count_next = '0;
          end else begin
            half_step_next = half_step + 2'd1;
          end
        end
        SEG_DEVW, SEG_ADDR, SEG_DATA, SEG_DEVR: begin
          pull = ~sb_cur[7];
          if (half_step == 2'd0) begin
            scl             = 1'b0;
            half_step_next  = 2'd1;
            shift_byte_next = sb_cur;
          end else begin
            shift_byte_next = {sb_cur[6:0], 1'b0};
            bit_count_next  = bc_inc;
            half_step_next  = '0;
            if (bc_inc == 3'd0) phase_next = phase + PHASE_W'(1);
          end
        end
        SEG_ACK, SEG_READ, SEG_NACK: begin
          if (half_step == 2'd0) begin
            scl            = 1'b0;
            half_step_next = 2'd1;
          end else if (kind == SEG_READ) begin
            received_byte_next = {received_byte[6:0], sda_in};
            bit_count_next     = bc_inc;
            half_step_next     = '0;
            if (bc_inc == 3'd0) phase_next = phase + PHASE_W'(1);
          end else begin
            if (kind == SEG_ACK && sda_in) ack_fail_next = 1'b1;
            phase_next     = phase + PHASE_W'(1);
            half_step_next = '0;
            bit_count_next = '0;
          end
        end
        default: begin
          scl  = (half_step != 2'd0);
          pull = ~half_step[1];
          if (half_step[1]) begin
            done           = 1'b1;
            phase_next     = '0;
            half_step_next = '0;
            bit_count_next = '0;
          end else begin
            half_step_next = half_step + 2'd1;
          end
        end
      endcase
    end

    res.scl          = scl;
    res.sda_pull_low = pull;
    res.busy_res     = (phase_next != '0);
    res.done_res     = done;
    res.ack_error    = ack_fail_next;
    res.rx_data      = received_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= '0;
      bit_count       <= '0;
      half_step       <= '0;
      shift_byte      <= '0;
      is_read         <= 1'b0;
      latched_address <= '0;
      latched_data    <= '0;
      received_byte   <= '0;
      ack_fail        <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      bit_count       <= bit_count_next;
      half_step       <= half_step_next;
      shift_byte      <= shift_byte_next;
      is_read         <= is_read_next;
      latched_address <= latched_address_next;
      latched_data    <= latched_data_next;
      received_byte   <= received_byte_next;
      ack_fail        <= ack_fail_next;
    end
  end

endmodule

// File: rtl/i2c_master_eeprom_access.sv
// Each accepted input word's result word is registered and offered the cycle after.
// Throughput: one word per cycle; the result register frees itself in the
// cycle it is taken, so input is held off only while a result waits.
// Reset (synchronous, rst high): sequencer idle, sequencer state cleared,
// device address back to 0x50, no result pending.
module i2c_master_eeprom_access
  import i2cee_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // word_address, write_data, sda_in, zero pad
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl, sda_pull_low, busy_res, done_res,
                                 // ack_error, rx_data, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // slave_addr
);

  logic [6:0] slave_addr;
  logic       step;
  res_t       res;

  assign s_tready  = ~m_tvalid | m_tready;
  assign cfg_ready = 1'b1;
  assign step      = s_tvalid & s_tready;

  i2cee_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .opcode       (s_tuser),
    .word_address (s_tdata[7:0]),
    .write_data   (s_tdata[15:8]),
    .sda_in       (s_tdata[16]),
    .slave_addr   (slave_addr),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_addr <= 7'd80;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) slave_addr <= cfg_data;
      if (step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) m_tdata <= {3'b000, res};
  end

endmodule

// File: rtl/i2cee_chk.sv
module i2cee_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // input open whenever no result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input held off with no result waiting");

  // end of STOP leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> !m_tdata[2])
    else $error("done with busy still set");

  // last STOP phase releases both lines
  a_done_lines: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[0] && !m_tdata[1])
    else $error("STOP did not end with lines released");

  // idle words show the bus released
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] && !m_tdata[3] |-> m_tdata[0] && !m_tdata[1])
    else $error("bus driven while idle");

endmodule

bind i2c_master_eeprom_access i2cee_chk u_chk (.*);

// File: sim/i2cee_bus_checker.sv
module i2cee_bus_checker
  import i2cee_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // word_address, write_data, sda_in, zero pad
  input  logic [1:0]  s_tuser,   // opcode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // scl, sda_pull_low, busy_res, done_res,
                                 // ack_error, rx_data, zero pad
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,  // slave_addr
  output int          errors,
  output int          pending
);

  seg_t wr_plan [8];
  seg_t rd_plan [11];

  logic [6:0] dev_addr;
  logic [4:0] seg_no;     // 0 idle, else 1 + segment index
  logic [2:0] bit_cnt;
  logic [1:0] half;
  logic [7:0] shifter;
  logic       rd_mode;
  logic [7:0] addr_lat;
  logic [7:0] data_lat;
  logic [7:0] rx_byte;
  logic       ack_bad;

  res_t bus_words_due [$];

  initial begin
    errors  = 0;
    pending = 0;
    wr_plan = '{SEG_START, SEG_DEVW, SEG_ACK, SEG_ADDR, SEG_ACK, SEG_DATA, SEG_ACK,
                SEG_STOP};
    rd_plan = '{SEG_START, SEG_DEVW, SEG_ACK, SEG_ADDR, SEG_ACK, SEG_START, SEG_DEVR,
                SEG_ACK, SEG_READ, SEG_NACK, SEG_STOP};
  end

  task automatic next_seg();
    seg_no  = seg_no + 5'd1;
    half    = 2'd0;
    bit_cnt = 3'd0;
  endtask

  // One half-bit phase of the bus for one input word
  task automatic advance_bus(input logic [1:0] op, input logic [7:0] wa, input logic [7:0] wd,
                             input logic sda, output res_t r);
    seg_t k;
    logic [1:0] hs;
    r     = '0;
    r.scl = 1'b1;
    hs    = half;
    if (seg_no == 5'd0) begin
      if (op == OP_WRITE || op == OP_READ) begin
        rd_mode  = (op == OP_READ);
        addr_lat = wa;
        data_lat = wd;
        ack_bad  = 1'b0;
        if (rd_mode) rx_byte = 8'd0;
        seg_no  = 5'd1;
        half    = 2'd0;
        bit_cnt = 3'd0;
      end
    end else begin
      k = rd_mode ? rd_plan[seg_no - 5'd1] : wr_plan[seg_no - 5'd1];
      case (k)
        SEG_START: begin
          r.scl          = (hs == 2'd1 || hs == 2'd2);
          r.sda_pull_low = (hs >= 2'd2);
          if (hs == 2'd3) next_seg();
          else half = hs + 2'd1;
        end
        SEG_DEVW, SEG_ADDR, SEG_DATA, SEG_DEVR: begin
          if (hs == 2'd0 && bit_cnt == 3'd0) begin
            case (k)
              SEG_DEVW: shifter = {dev_addr, 1'b0};
              SEG_DEVR: shifter = {dev_addr, 1'b1};
              SEG_ADDR: shifter = addr_lat;
              default:  shifter = data_lat;
            endcase
          end
          r.sda_pull_low = !shifter[7];
          if (hs == 2'd0) begin
            r.scl = 1'b0;
            half  = 2'd1;
          end else begin
            shifter = shifter << 1;
            bit_cnt = bit_cnt + 3'd1;
            half    = 2'd0;
            if (bit_cnt == 3'd0) next_seg();
          end
        end
        SEG_ACK, SEG_READ, SEG_NACK: begin
          if (hs == 2'd0) begin
            r.scl = 1'b0;
            half  = 2'd1;
          end else if (k == SEG_ACK) begin
            if (sda) ack_bad = 1'b1;
            next_seg();
          end else if (k == SEG_NACK) begin
            next_seg();
          end else begin
            rx_byte = {rx_byte[6:0], sda};
            bit_cnt = bit_cnt + 3'd1;
            half    = 2'd0;
            if (bit_cnt == 3'd0) next_seg();
          end
        end
        default: begin
          r.scl          = (hs != 2'd0);
          r.sda_pull_low = (hs <= 2'd1);
          if (hs >= 2'd2) begin
            r.done_res = 1'b1;
            seg_no     = 5'd0;
            half       = 2'd0;
            bit_cnt    = 3'd0;
          end else begin
            half = hs + 2'd1;
          end
        end
      endcase
    end
    r.busy_res  = (seg_no != 5'd0);
    r.ack_error = ack_bad;
    r.rx_data   = rx_byte;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (rst) begin
      dev_addr = 7'd80;
      seg_no   = 5'd0;
      bit_cnt  = 3'd0;
      half     = 2'd0;
      shifter  = 8'd0;
      rd_mode  = 1'b0;
      addr_lat = 8'd0;
      data_lat = 8'd0;
      rx_byte  = 8'd0;
      ack_bad  = 1'b0;
      bus_words_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[12:0]);
        if (bus_words_due.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual %0h", $time, m_tdata);
          errors++;
        end else begin
          want = bus_words_due.pop_front();
          compare_field("scl", want.scl, got.scl);
          compare_field("sda_pull_low", want.sda_pull_low, got.sda_pull_low);
          compare_field("busy_res", want.busy_res, got.busy_res);
          compare_field("done_res", want.done_res, got.done_res);
          compare_field("ack_error", want.ack_error, got.ack_error);
          compare_field("rx_data", want.rx_data, got.rx_data);
        end
      end
      if (cfg_valid && cfg_ready) dev_addr = cfg_data;
      if (s_tvalid && s_tready) begin
        advance_bus(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[16], want);
        bus_words_due.push_back(want);
      end
    end
    pending = bus_words_due.size();
  end

endmodule

// File: sim/tb_i2c_master_eeprom_access.sv
module tb_i2c_master_eeprom_access;
  import i2cee_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WRITE_WORDS = 62;
  localparam int READ_WORDS  = 84;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'd0;
  logic [1:0]  s_tuser = OP_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = 7'd0;

  int errors;
  int pending;
  int cycles = 0;
  int sent = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  always #10 clk = ~clk;

  i2c_master_eeprom_access DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  i2cee_bus_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic send_word(input opcode_t op, input logic [7:0] wa, input logic [7:0] wd,
                           input logic sda);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, sda, wd, wa};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // hold off input until every word sent has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_device_address(input logic [6:0] a);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // command word, then further words up to the given count, mostly ticks; stray commands land while busy
  task automatic run_transfer(input logic rd, input logic [7:0] wa, input logic [7:0] wd,
                              input int sda_pct, input int words, input int cfg_at,
                              input logic [6:0] new_addr);
    opcode_t op;
    int r;
    send_word(rd ? OP_READ : OP_WRITE, wa, wd, 1'($urandom_range(1)));
    for (int i = 1; i < words; i++) begin
      if (i == cfg_at) write_device_address(new_addr);
      r  = $urandom_range(99);
      op = (r < 4) ? OP_WRITE : (r < 8) ? OP_READ : (r < 12) ? OP_SPARE : OP_TICK;
      send_word(op, 8'($urandom), 8'($urandom), ($urandom_range(99) < sda_pct));
    end
  endtask

  initial begin
    int goal;
    int sda_pct;
    int words;
    int cfg_at;
    logic rd;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // idle ticks, spare opcode, field extremes
    send_word(OP_TICK, 8'hFF, 8'hFF, 1'b1);
    send_word(OP_SPARE, 8'h00, 8'h00, 1'b0);
    send_word(OP_SPARE, 8'hFF, 8'hFF, 1'b1);
    run_transfer(1'b0, 8'hFF, 8'h00, 0, WRITE_WORDS, -1, 7'd0);
    write_device_address(7'h7F);
    run_transfer(1'b1, 8'h00, 8'hFF, 100, READ_WORDS, -1, 7'd0);
    // address change mid-transaction, only the later device byte sees it
    run_transfer(1'b1, 8'h5A, 8'hA5, 0, READ_WORDS, 30, 7'h00);
    run_transfer(1'b0, 8'hA5, 8'hFF, 100, WRITE_WORDS, -1, 7'd0);

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 56 : 0;
      rcv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 17 : 0;
      write_device_address((ph == 0) ? 7'h7F : (ph == 1) ? 7'h00 : 7'($urandom));
      goal = sent + 480;
      while (sent < goal) begin
        if ($urandom_range(99) < 20) begin
          repeat ($urandom_range(8, 1))
            send_word(opcode_t'($urandom_range(3)), 8'($urandom), 8'($urandom),
                      1'($urandom_range(1)));
        end
        if ($urandom_range(99) < 10) write_device_address(7'($urandom));
        rd = 1'($urandom_range(1));
        words = rd ? READ_WORDS : WRITE_WORDS;
        if ($urandom_range(99) < 8) words = $urandom_range(words - 1, 2);
        cfg_at = ($urandom_range(99) < 10) ? $urandom_range(words - 1, 1) : -1;
        case ($urandom_range(3))
          0:       sda_pct = 0;
          1:       sda_pct = 5;
          2:       sda_pct = 50;
          default: sda_pct = 100;
        endcase
        run_transfer(rd, 8'($urandom), 8'($urandom), sda_pct, words, cfg_at, 7'($urandom));
      end
    end

    drain();
    repeat (3) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/i2cee_pkg.sv
rtl/i2cee_seq.sv
rtl/i2c_master_eeprom_access.sv
rtl/i2cee_chk.sv
sim/i2cee_bus_checker.sv
sim/tb_i2c_master_eeprom_access.sv
